// ===== rtl/svu_pkg.sv =====
package svu_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 15;
    localparam int DB_W     = 15;
    localparam int VOL_W    = 7;

    // Square-law gain curve
    localparam int LEVEL_STEPS = 128;
    localparam int LVL_IDX_W   = $clog2(LEVEL_STEPS);
    localparam int GAIN_W      = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
    localparam longint unsigned GAIN_DEN =
        longint'(LEVEL_STEPS - 1) * longint'(LEVEL_STEPS - 1);

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Reciprocals: floor(y/25) = (y*M200)>>30 for y < 2^30,
    // floor(y/5) = (y*M5)>>20 for y < 2^18
    localparam logic [MUL_W-1:0] C199 = 32'd199;
    localparam logic [MUL_W-1:0] M200 = 32'd42949673;
    localparam logic [MUL_W-1:0] M5   = 32'd209716;
    // 2000*log10(2) in Q16
    localparam logic [MUL_W-1:0] DB_K = 32'd39456605;

    // log2 in Q16
    localparam int MANT_W    = 31;
    localparam int FRAC_BITS = 16;
    localparam int ROUND_W   = $clog2(FRAC_BITS);
    localparam int IPART_W   = 4;
    localparam int LOG_W     = IPART_W + FRAC_BITS;

    localparam logic [15:0]     DB_FLOOR_MAG = 16'd9100;
    localparam logic [DB_W-1:0] DB_FLOOR     = 15'd23668; // -9100

    // Microcode
    localparam int STEP_W = 4;

    typedef logic [GAIN_W-1:0] t_gain_tab [LEVEL_STEPS];

    function automatic t_gain_tab f_gain_tab();
        t_gain_tab t;
        longint unsigned ii;
        for (int k = 0; k < LEVEL_STEPS; k++) begin
            ii = longint'(k);
            t[k] = GAIN_W'((ii * ii * 64'd65536 + GAIN_DEN / 2) / GAIN_DEN);
        end
        return t;
    endfunction

    localparam t_gain_tab GAIN_TAB = f_gain_tab();

    // Same log2 as the datapath; evaluated once for full scale
    function automatic logic [LOG_W-1:0] f_log2_q16(input logic [ENV_W-1:0] x);
        longint unsigned m;
        longint unsigned r;
        int              e;
        e = 0;
        for (int b = 0; b < ENV_W; b++) begin
            if (x[b]) e = b;
        end
        m = longint'(x) << (30 - e);
        r = longint'(e) * 64'd65536;
        for (int k = FRAC_BITS - 1; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r = r + (64'd1 << k);
            end
        end
        return LOG_W'(r);
    endfunction

    localparam logic [LOG_W-1:0] LOG_FULL = f_log2_q16(15'd32767);

    typedef enum logic [2:0] {
        MA_ZERO,
        MA_GAIN,
        MA_QUOT,
        MA_ABS_S,
        MA_ENV_SUM,
        MA_MANT,
        MA_DB_DIFF
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_ZERO,
        MB_C199,
        MB_M200,
        MB_GAIN,
        MB_M5,
        MB_MANT,
        MB_DBK
    } t_mul_b;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_LOOP,
        SQ_END
    } t_seq;

    typedef struct packed {
        t_mul_a            mul_a;
        t_mul_b            mul_b;
        logic              wr_gain;
        logic              wr_out;
        logic              wr_env;
        logic              ld_norm;
        logic              ld_loop;
        logic              upd_mant;
        logic              wr_result;
        t_seq              seq;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul_a:     MA_ZERO,
        mul_b:     MB_ZERO,
        wr_gain:   1'b0,
        wr_out:    1'b0,
        wr_env:    1'b0,
        ld_norm:   1'b0,
        ld_loop:   1'b0,
        upd_mant:  1'b0,
        wr_result: 1'b0,
        seq:       SQ_NEXT,
        target:    '0
    };

endpackage

// ===== rtl/svu_sequencer.sv =====
module svu_sequencer
    import svu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_out_free,
    output logic               o_busy,
    output logic               o_step_en,
    output t_uword             o_uword,
    output logic [ROUND_W-1:0] o_round
);

    localparam logic [STEP_W-1:0] ST_G199   = 4'd0;
    localparam logic [STEP_W-1:0] ST_DIV200 = 4'd1;
    localparam logic [STEP_W-1:0] ST_GAIN   = 4'd2;
    localparam logic [STEP_W-1:0] ST_SCALE  = 4'd3;
    localparam logic [STEP_W-1:0] ST_OUT    = 4'd4;
    localparam logic [STEP_W-1:0] ST_DIV5   = 4'd5;
    localparam logic [STEP_W-1:0] ST_ENV    = 4'd6;
    localparam logic [STEP_W-1:0] ST_NORM   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SQUARE = 4'd8;
    localparam logic [STEP_W-1:0] ST_ROUND  = 4'd9;
    localparam logic [STEP_W-1:0] ST_DBMUL  = 4'd10;
    localparam logic [STEP_W-1:0] ST_RESULT = 4'd11;

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            ST_G199: begin
                w.mul_a = MA_GAIN;
                w.mul_b = MB_C199;
            end
            ST_DIV200: begin
                w.mul_a = MA_QUOT;
                w.mul_b = MB_M200;
            end
            ST_GAIN: begin
                w.wr_gain = 1'b1;
            end
            ST_SCALE: begin
                w.mul_a = MA_ABS_S;
                w.mul_b = MB_GAIN;
            end
            ST_OUT: begin
                w.wr_out = 1'b1;
            end
            ST_DIV5: begin
                w.mul_a = MA_ENV_SUM;
                w.mul_b = MB_M5;
            end
            ST_ENV: begin
                w.wr_env = 1'b1;
            end
            ST_NORM: begin
                w.ld_norm = 1'b1;
                w.ld_loop = 1'b1;
            end
            ST_SQUARE: begin
                w.mul_a = MA_MANT;
                w.mul_b = MB_MANT;
            end
            ST_ROUND: begin
                w.upd_mant = 1'b1;
                w.seq      = SQ_LOOP;
                w.target   = ST_SQUARE;
            end
            ST_DBMUL: begin
                w.mul_a = MA_DB_DIFF;
                w.mul_b = MB_DBK;
            end
            ST_RESULT: begin
                w.wr_result = 1'b1;
                w.seq       = SQ_END;
            end
            default: begin
                w.seq = SQ_END;
            end
        endcase
        return w;
    endfunction

    logic               r_busy;
    logic [STEP_W-1:0]  r_pc;
    logic [ROUND_W-1:0] r_loop;
    t_uword             uw;
    logic               step_en;

    assign uw      = f_ucode(r_pc);
    // hold on the last step while the output register is still full
    assign step_en = r_busy && !(uw.wr_result && !i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_loop <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= ST_G199;
            end
        end else if (step_en) begin
            if (uw.ld_loop) begin
                r_loop <= ROUND_W'(FRAC_BITS - 1);
            end
            unique case (uw.seq)
                SQ_NEXT: begin
                    r_pc <= r_pc + 1'b1;
                end
                SQ_LOOP: begin
                    if (r_loop != '0) begin
                        r_pc   <= uw.target;
                        r_loop <= r_loop - 1'b1;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                SQ_END: begin
                    r_busy <= 1'b0;
                    r_pc   <= ST_G199;
                end
                default: begin
                    r_busy <= 1'b0;
                    r_pc   <= ST_G199;
                end
            endcase
        end
    end

    assign o_busy    = r_busy;
    assign o_step_en = step_en;
    assign o_uword   = uw;
    assign o_round   = r_loop;

endmodule

// ===== rtl/svu_datapath.sv =====
module svu_datapath
    import svu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [VOL_W-1:0]           i_volume,
    input  logic                       i_mute,
    input  logic                       i_step_en,
    input  t_uword                     i_uword,
    input  logic [ROUND_W-1:0]         i_round,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic [ENV_W-1:0]           o_envelope,
    output logic signed [DB_W-1:0]     o_level_db
);

    logic [GAIN_W-1:0]    r_gain;
    logic [ENV_W-1:0]     r_env;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [SAMPLE_W-1:0]  r_out_s;
    logic [PROD_W-1:0]    r_prod;
    logic [MANT_W-1:0]    r_mant;
    logic [IPART_W-1:0]   r_ipart;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_zero;

    logic [LVL_IDX_W-1:0] idx;
    logic [GAIN_W-1:0]    tgt;
    logic [24:0]          sum200;
    logic [21:0]          quot;
    logic [17:0]          gain_q;
    logic [GAIN_W-1:0]    n_gain;
    logic [16:0]          abs_s;
    logic [16:0]          mag;
    logic [SAMPLE_W-1:0]  n_out_s;
    logic [16:0]          abs_o;
    logic [17:0]          env_sum;
    logic [16:0]          env_q;
    logic [ENV_W-1:0]     n_env;
    logic [IPART_W-1:0]   top_bit;
    logic [4:0]           norm_sh;
    logic [31:0]          mq;
    logic [LOG_W-1:0]     db_diff;
    logic [47:0]          db_round;
    logic [15:0]          db_mag;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;

    // target gain
    always_comb begin
        if (i_volume > VOL_W'(LEVEL_STEPS - 1)) begin
            idx = LVL_IDX_W'(LEVEL_STEPS - 1);
        end else begin
            idx = LVL_IDX_W'(i_volume);
        end
        tgt = i_mute ? '0 : GAIN_TAB[idx];
    end

    // (199*g + T + 100) / 200 as (x>>3) / 25
    assign sum200 = 25'(r_prod[23:0]) + 25'(tgt) + 25'd100;
    assign quot   = sum200[24:3];
    assign gain_q = r_prod[47:30];
    assign n_gain = (gain_q > 18'(GAIN_ONE)) ? GAIN_ONE : gain_q[GAIN_W-1:0];

    assign abs_s = r_sample[SAMPLE_W-1] ? (~{r_sample[SAMPLE_W-1], r_sample} + 17'd1)
                                        : {1'b0, r_sample};
    assign mag   = r_prod[32:16];

    always_comb begin
        if (r_sample[SAMPLE_W-1]) begin
            n_out_s = (mag > 17'd32768) ? 16'h8000 : SAMPLE_W'(~mag + 17'd1);
        end else begin
            n_out_s = (mag > 17'd32767) ? 16'h7FFF : mag[SAMPLE_W-1:0];
        end
    end

    assign abs_o   = r_out_s[SAMPLE_W-1] ? (~{r_out_s[SAMPLE_W-1], r_out_s} + 17'd1)
                                         : {1'b0, r_out_s};
    assign env_sum = 18'({r_env, 2'b00}) + 18'(abs_o);
    assign env_q   = r_prod[36:20];
    assign n_env   = (env_q > 17'd32767) ? 15'h7FFF : env_q[ENV_W-1:0];

    // position of the top set bit of the envelope
    always_comb begin
        top_bit = '0;
        for (int b = 0; b < ENV_W; b++) begin
            if (r_env[b]) top_bit = IPART_W'(b);
        end
        norm_sh = 5'd30 - 5'(top_bit);
    end

    assign mq       = r_prod[61:30];
    assign db_diff  = LOG_FULL - {r_ipart, r_frac};
    assign db_round = r_prod[47:0] + 48'h0000_8000_0000;
    assign db_mag   = db_round[47:32];

    always_comb begin
        unique case (i_uword.mul_a)
            MA_ZERO:    mul_a = '0;
            MA_GAIN:    mul_a = MUL_W'(r_gain);
            MA_QUOT:    mul_a = MUL_W'(quot);
            MA_ABS_S:   mul_a = MUL_W'(abs_s);
            MA_ENV_SUM: mul_a = MUL_W'(env_sum);
            MA_MANT:    mul_a = MUL_W'(r_mant);
            MA_DB_DIFF: mul_a = MUL_W'(db_diff);
            default:    mul_a = '0;
        endcase
        unique case (i_uword.mul_b)
            MB_ZERO: mul_b = '0;
            MB_C199: mul_b = C199;
            MB_M200: mul_b = M200;
            MB_GAIN: mul_b = MUL_W'(r_gain);
            MB_M5:   mul_b = M5;
            MB_MANT: mul_b = MUL_W'(r_mant);
            MB_DBK:  mul_b = DB_K;
            default: mul_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
            r_env  <= '0;
        end else if (i_step_en) begin
            if (i_uword.wr_gain) r_gain <= n_gain;
            if (i_uword.wr_env)  r_env  <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sample <= $unsigned(i_sample);
        end
        if (i_step_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            if (i_uword.wr_out) begin
                r_out_s <= n_out_s;
            end
            if (i_uword.ld_norm) begin
                r_mant  <= MANT_W'(32'(r_env) << norm_sh);
                r_ipart <= top_bit;
                r_frac  <= '0;
                r_zero  <= (r_env == '0);
            end
            if (i_uword.upd_mant) begin
                if (mq[31]) begin
                    r_mant          <= mq[31:1];
                    r_frac[i_round] <= 1'b1;
                end else begin
                    r_mant <= mq[MANT_W-1:0];
                end
            end
        end
    end

    assign o_out_sample = $signed(r_out_s);
    assign o_envelope   = r_env;
    assign o_level_db   = (r_zero || db_mag > DB_FLOOR_MAG) ? $signed(DB_FLOOR)
                                                            : $signed(DB_W'(~db_mag + 16'd1));

endmodule

// ===== rtl/smoothed_volume_with_envelope_unit.sv =====
// Smoothed volume stage with envelope follower. Each sample request moves a Q1.16 gain one
// step (coefficient 1/200) toward the square-law target (volume_level/127)^2, or toward zero
// when mute is set, scales the sample by it (truncated toward zero), updates the envelope
// 0.8*env + 0.2*|out| and reports that envelope in 0.01 dB below full scale, floored at
// -9100. One shared 32x32 multiplier is driven by a 12-step microcode program; most of a
// request's run is the 16 squaring rounds of the log2, each a square step and a round step.
// A request is accepted only when the unit is idle; the last step stalls while the output
// register is still full. The next sample is accepted while a result waits to be taken.
// Configuration registers: index 0 volume_level (reset 127), index 1 mute (reset 0); write
// them only while no request is in flight.
module smoothed_volume_with_envelope_unit
    import svu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic [ENV_W-1:0]           o_envelope,
    output logic signed [DB_W-1:0]     o_level_db_centi,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [VOL_W-1:0]           i_cfg_data
);

    localparam logic [1:0] CFG_VOLUME = 2'd0;
    localparam logic [1:0] CFG_MUTE   = 2'd1;

    logic [VOL_W-1:0]           r_volume;
    logic                       r_mute;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [ENV_W-1:0]           r_envelope;
    logic signed [DB_W-1:0]     r_level_db;

    logic                       start;
    logic                       out_free;
    logic                       busy;
    logic                       step_en;
    t_uword                     uword;
    logic [ROUND_W-1:0]         round;
    logic                       load_result;
    logic signed [SAMPLE_W-1:0] dp_out_sample;
    logic [ENV_W-1:0]           dp_envelope;
    logic signed [DB_W-1:0]     dp_level_db;

    assign o_in_ready  = !busy;
    assign start       = i_in_valid && !busy;
    assign out_free    = !r_out_valid || i_out_ready;
    assign load_result = step_en && uword.wr_result;
    assign o_cfg_ready = 1'b1;

    svu_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_step_en  (step_en),
        .o_uword    (uword),
        .o_round    (round)
    );

    svu_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_sample     (i_sample),
        .i_volume     (r_volume),
        .i_mute       (r_mute),
        .i_step_en    (step_en),
        .i_uword      (uword),
        .i_round      (round),
        .o_out_sample (dp_out_sample),
        .o_envelope   (dp_envelope),
        .o_level_db   (dp_level_db)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= 7'd127;
            r_mute   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VOLUME: r_volume <= i_cfg_data;
                CFG_MUTE:   r_mute   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_out_sample <= dp_out_sample;
            r_envelope   <= dp_envelope;
            r_level_db   <= dp_level_db;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_sample     = r_out_sample;
    assign o_envelope       = r_envelope;
    assign o_level_db_centi = r_level_db;

endmodule

// ===== tb/tb_smoothed_volume_with_envelope_unit.sv =====
module tb_smoothed_volume_with_envelope_unit;
    import svu_pkg::*;

    localparam logic [1:0] REG_VOLUME = 2'd0;
    localparam logic [1:0] REG_MUTE   = 2'd1;
    localparam logic [1:0] REG_SPARE2 = 2'd2;
    localparam logic [1:0] REG_SPARE3 = 2'd3;

    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int TARGET_ITEMS = 1850;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int ENV_MAX    = 32767;
    localparam int DB_MIN     = -9100;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic [ENV_W-1:0]           envelope;
        logic [DB_W-1:0]            level_db;
    } t_scaled;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [1:0]                 idx;
        logic [VOL_W-1:0]           data;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       typed;
        t_scaled                    res;
    } t_dir_row;

    localparam t_scaled SILENT = '{16'sd0, 15'd0, DB_FLOOR};
    localparam t_scaled NO_RES = '0;
    localparam int N_DIR = 23;

    // typed rows: silence right after reset, unity gain, empty envelope
    localparam t_dir_row DIRECTED [N_DIR] = '{
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh0000, 1'b1, SILENT},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh0000, 1'b1, SILENT},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh7FFF, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'shFFFF, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh0001, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh5555, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'shAAAA, 1'b0, NO_RES},
        '{ROW_CFG,    REG_MUTE,   7'h01, 16'sh0000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh7FFF, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh8000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_SPARE2, 7'h7F, 16'sh0000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_SPARE3, 7'h7F, 16'sh0000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh3039, 1'b0, NO_RES},
        // upper bits of a mute write are dropped, so this clears mute
        '{ROW_CFG,    REG_MUTE,   7'h7E, 16'sh0000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_VOLUME, 7'h00, 16'sh0000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh7FFF, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh8000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_MUTE,   7'h01, 16'sh0000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_VOLUME, 7'h7F, 16'sh0000, 1'b0, NO_RES},
        '{ROW_CFG,    REG_MUTE,   7'h00, 16'sh0000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'shB1E0, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_VOLUME, 7'h00, 16'sh0000, 1'b0, NO_RES}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] in_sample = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [1:0]                 cfg_index = '0;
    logic [VOL_W-1:0]           cfg_data = '0;

    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_out_sample;
    logic [ENV_W-1:0]           o_envelope;
    logic signed [DB_W-1:0]     o_level_db_centi;
    logic                       o_cfg_ready;

    // predictor state
    logic [VOL_W-1:0] vol_q = 7'd127;
    logic             mute_q = 1'b0;
    longint unsigned  gain_q = 65536;
    longint unsigned  env_q = 0;

    t_scaled pending_scaled [$];
    int      n_fail = 0;
    int      n_checked = 0;
    int      n_sent = 0;
    int      n_writes = 0;
    int      n_floor = 0;
    int      burst_left = 0;
    int      stall_cnt = 0;
    longint unsigned gain_lo = 65536;
    longint unsigned gain_hi = 0;
    longint unsigned env_peak = 0;

    logic hold_tgl = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   seg_left = 0;
    int   stall_mode = 0;

    smoothed_volume_with_envelope_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (in_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_out_sample     (o_out_sample),
        .o_envelope       (o_envelope),
        .o_level_db_centi (o_level_db_centi),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // log2 in Q16 by repeated squaring of a Q30 mantissa
    function automatic longint log2_fix(input longint unsigned x);
        longint unsigned m;
        longint          r;
        int              msb;
        msb = 0;
        while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
        m = x << (30 - msb);
        r = longint'(msb) * 65536;
        for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r = r + (longint'(1) << k);
            end
        end
        return r;
    endfunction

    function automatic t_scaled scale_and_follow(input logic signed [SAMPLE_W-1:0] s);
        longint unsigned den;
        longint unsigned lvl;
        longint unsigned tgt;
        longint          sl;
        longint          p;
        longint          o;
        longint unsigned a;
        longint unsigned e;
        longint unsigned d;
        longint unsigned c;
        int              db;
        t_scaled         res;
        den = longint'(LEVEL_STEPS - 1) * longint'(LEVEL_STEPS - 1);
        lvl = vol_q;
        if (lvl > LEVEL_STEPS - 1) lvl = LEVEL_STEPS - 1;
        tgt = mute_q ? 0 : (lvl * lvl * 65536 + den / 2) / den;
        gain_q = (gain_q * 199 + tgt + 100) / 200;
        if (gain_q > 65536) gain_q = 65536;
        sl = s;
        p = sl * longint'(gain_q);
        o = (p < 0 ? -p : p) >> 16;
        if (p < 0) o = -o;
        if (o > SAMPLE_MAX) o = SAMPLE_MAX;
        if (o < SAMPLE_MIN) o = SAMPLE_MIN;
        a = unsigned'(o < 0 ? -o : o);
        e = (4 * env_q + a) / 5;
        if (e > ENV_MAX) e = ENV_MAX;
        env_q = e;
        if (e == 0) begin
            db = DB_MIN;
        end else begin
            d = unsigned'(log2_fix(ENV_MAX) - log2_fix(e));
            c = (d * 64'(DB_K) + 64'h8000_0000) >> 32;
            db = (c > -DB_MIN) ? DB_MIN : -int'(c);
        end
        if (db == DB_MIN) n_floor++;
        if (gain_q < gain_lo) gain_lo = gain_q;
        if (gain_q > gain_hi) gain_hi = gain_q;
        if (e > env_peak) env_peak = e;
        res.out_sample = SAMPLE_W'(o);
        res.envelope   = ENV_W'(e);
        res.level_db   = DB_W'(db);
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
        int                         sel;
        logic signed [SAMPLE_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (style == 0 && sel < 7) return '0;
        case (sel)
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: begin
                v = SAMPLE_W'($urandom_range(0, 511));
                v = v - 16'sd256;
            end
            3: v = '0;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                               input t_scaled typed_res);
        t_scaled r;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        do @(posedge clk); while (!o_in_ready);
        burst_left--;
        r = scale_and_follow(s);
        pending_scaled.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [VOL_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_scaled.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_VOLUME: vol_q = data;
            REG_MUTE:   mute_q = data[0];
            default: ;
        endcase
        n_writes++;
    endtask

    // receiver: segments of free flow, random and heavy stalls; long hold on request
    always @(posedge clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left   <= $urandom_range(8, 120);
                stall_mode <= $urandom_range(0, 2);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_results
        t_scaled want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_scaled.size() == 0) begin
                $error("result with no request outstanding: out_sample %0d", o_out_sample);
                n_fail++;
            end else begin
                want = pending_scaled.pop_front();
                n_checked++;
                if (o_out_sample !== want.out_sample) begin
                    $error("out_sample: expected %0d, got %0d", want.out_sample, o_out_sample);
                    n_fail++;
                end
                if (o_envelope !== want.envelope) begin
                    $error("envelope: expected %0d, got %0d", want.envelope, o_envelope);
                    n_fail++;
                end
                if (o_level_db_centi !== want.level_db) begin
                    $error("level_db_centi: expected %0d, got %0d",
                           $signed(want.level_db), o_level_db_centi);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int               phase;
        int               n_items;
        int               style;
        logic [VOL_W-1:0] vol;
        logic             mute_bit;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].res);
            end
        end

        phase = 0;
        while (n_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 5))
                0: vol = 7'd0;
                1: vol = 7'd127;
                default: vol = VOL_W'($urandom);
            endcase
            mute_bit = ($urandom_range(0, 4) == 0);
            write_reg(REG_VOLUME, vol);
            write_reg(REG_MUTE, {6'($urandom), mute_bit});
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE3 : REG_SPARE2, 7'($urandom));
            style = $urandom_range(0, 3);
            n_items = (mute_bit || vol == 0) ? $urandom_range(100, 450) : $urandom_range(20, 250);
            for (int k = 0; k < n_items && n_sent < TARGET_ITEMS; k++) begin
                // stall the result side long enough to back up the input
                if (phase == 2 && k == 5) hold_tgl <= ~hold_tgl;
                send_sample(pick_sample(style), 1'b0, NO_RES);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_scaled.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_scaled.size() != 0) begin
            $error("%0d results never arrived", pending_scaled.size());
            n_fail++;
        end

        $display("%0d samples over %0d settings phases, %0d results checked, %0d reg writes",
                 n_sent, phase, n_checked, n_writes);
        $display("gain swept %0d..%0d (Q1.16), envelope peak %0d, %0d floor dB readings",
                 gain_lo, gain_hi, env_peak, n_floor);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/svu_pkg.sv
rtl/svu_sequencer.sv
rtl/svu_datapath.sv
rtl/smoothed_volume_with_envelope_unit.sv
tb/tb_smoothed_volume_with_envelope_unit.sv
